FILE: hdl/fsrf_pkg.sv
`timescale 1ns / 1ps

package fsrf_pkg;

    localparam int POS_BITS       = 24;
    localparam int ADDR_BITS      = 24;
    localparam int BANK_BYTES     = 32768;
    localparam int BANK_BITS      = $clog2(BANK_BYTES);
    localparam int HEADER_BYTES   = 8;
    localparam int WIN_DEPTH      = 8;
    localparam int FILL_BITS      = $clog2(WIN_DEPTH + 1);
    localparam int WIN_IDX_BITS   = $clog2(WIN_DEPTH);
    localparam int REQ_BITS       = 15;
    localparam int RUN_BITS       = 16;
    localparam int SKIP_BITS      = 17;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_DATA_BITS  = 24;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [REQ_BITS-1:0] MAX_REQUEST = 15'h7FF8;
    localparam logic [RUN_BITS-1:0] RUN_MAX     = 16'hFFFF;

    localparam logic [7:0] TAG_S = 8'h53;
    localparam logic [7:0] TAG_T = 8'h54;
    localparam logic [7:0] TAG_A = 8'h41;
    localparam logic [7:0] TAG_R = 8'h52;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_REQUEST_SIZE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_OFFSET    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AGGRESSIVE_MODE = 2'd2;

    typedef enum logic {
        ST_SCAN,
        ST_DRAIN
    } back_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       zero;
    } item_t;

    typedef struct packed {
        logic                 hit;
        logic                 shift;
        logic [POS_BITS-1:0]  addr;
        logic [RUN_BITS-1:0]  run;
        logic [SKIP_BITS-1:0] skip;
    } judge_t;

    function automatic logic [RUN_BITS-1:0] run_need(input logic [REQ_BITS-1:0] req);
        return RUN_BITS'(req) + RUN_BITS'(HEADER_BYTES);
    endfunction

    function automatic logic run_complete(input logic [RUN_BITS-1:0] run,
                                          input logic [REQ_BITS-1:0] req);
        return (req != '0) && (req <= MAX_REQUEST) && (run == run_need(req));
    endfunction

    function automatic logic [RUN_BITS-1:0] bump(input logic [RUN_BITS-1:0] run);
        return (run == RUN_MAX) ? run : run + RUN_BITS'(1);
    endfunction

    // judge the oldest window byte
    function automatic judge_t judge(input logic [WIN_DEPTH-1:0][7:0] win,
                                     input logic                    zero0,
                                     input logic                    full,
                                     input logic [RUN_BITS-1:0]     run,
                                     input logic [SKIP_BITS-1:0]    skip,
                                     input logic [POS_BITS-1:0]     pos,
                                     input logic [REQ_BITS-1:0]     req,
                                     input logic                    aggr);
        judge_t              j;
        logic [RUN_BITS-1:0] r;
        logic [15:0]         sz;
        logic [15:0]         inv;
        logic                tag;
        j.hit   = 1'b0;
        j.shift = 1'b1;
        j.addr  = pos - POS_BITS'(run_need(req));
        j.run   = run;
        j.skip  = skip;
        sz      = {win[5], win[4]};
        inv     = ~{win[7], win[6]};
        tag     = full && (win[0] == TAG_S) && (win[1] == TAG_T)
                  && (win[2] == TAG_A) && (win[3] == TAG_R);
        r       = (pos[BANK_BITS-1:0] == '0) ? '0 : run;
        if (skip != '0) begin
            j.skip = skip - SKIP_BITS'(1);
        end else if (run_complete(run, req)) begin
            j.hit   = 1'b1;
            j.shift = 1'b0;
        end else if (tag) begin
            if (sz != inv) begin
                j.run = bump(r);
            end else begin
                j.skip = SKIP_BITS'(sz) + SKIP_BITS'(HEADER_BYTES);
                j.run  = '0;
            end
        end else if (zero0 || aggr) begin
            j.run = bump(r);
        end else begin
            j.run = '0;
        end
        return j;
    endfunction

endpackage

FILE: hdl/fsrf_in_if.sv
`timescale 1ns / 1ps

interface fsrf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_image;

    modport source (output valid, output data_byte, output end_of_image, input ready);
    modport sink (input valid, input data_byte, input end_of_image, output ready);
endinterface

FILE: hdl/fsrf_out_if.sv
`timescale 1ns / 1ps

interface fsrf_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [23:0] block_address;

    modport source (output valid, output found, output block_address, input ready);
    modport sink (input valid, input found, input block_address, output ready);
endinterface

FILE: hdl/fsrf_front.sv
`timescale 1ns / 1ps

module fsrf_front
    import fsrf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    fsrf_in_if.sink       in_chan,
    output logic          q_valid,
    output item_t         q_item,
    input  logic          q_ready
);

    item_t                     mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic [QUEUE_CNT_BITS-1:0] count_next;
    logic                      push;
    logic                      pop;
    item_t                     item_in;

    assign in_chan.ready = (count_reg != QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign push          = in_chan.valid && in_chan.ready;
    assign q_valid       = (count_reg != '0);
    assign pop           = q_valid && q_ready;
    assign q_item        = mem_reg[rd_ptr_reg];

    // classify
    always_comb
    begin
        item_in.data_byte = in_chan.data_byte;
        item_in.last      = in_chan.end_of_image;
        item_in.zero      = (in_chan.data_byte == 8'h00);
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/fsrf_back.sv
`timescale 1ns / 1ps

module fsrf_back
    import fsrf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      q_valid,
    input  item_t                     q_item,
    output logic                      q_ready,
    fsrf_out_if.source                out_chan
);

    back_state_t                  state_reg;
    back_state_t                  state_next;
    logic [WIN_DEPTH-1:0][7:0]    win_reg;
    logic [WIN_DEPTH-1:0][7:0]    win_next;
    logic [WIN_DEPTH-1:0]         zero_reg;
    logic [WIN_DEPTH-1:0]         zero_next;
    logic [FILL_BITS-1:0]         fill_reg;
    logic [FILL_BITS-1:0]         fill_next;
    logic [POS_BITS-1:0]          pos_reg;
    logic [POS_BITS-1:0]          pos_next;
    logic [RUN_BITS-1:0]          run_reg;
    logic [RUN_BITS-1:0]          run_next;
    logic [SKIP_BITS-1:0]         skip_reg;
    logic [SKIP_BITS-1:0]         skip_next;
    logic                         done_reg;
    logic                         done_next;
    logic [REQ_BITS-1:0]          req_reg;
    logic [REQ_BITS-1:0]          req_next;
    logic [CFG_DATA_BITS-1:0]     start_reg;
    logic [CFG_DATA_BITS-1:0]     start_next;
    logic                         aggr_reg;
    logic                         aggr_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         found_reg;
    logic                         found_next;
    logic [ADDR_BITS-1:0]         addr_reg;
    logic [ADDR_BITS-1:0]         addr_next;

    logic                         out_free;
    logic                         pop;
    logic [WIN_DEPTH-1:0][7:0]    win_app;
    logic [WIN_DEPTH-1:0]         zero_app;
    logic [FILL_BITS-1:0]         fill_app;
    logic                         full_app;
    judge_t                       js;
    judge_t                       jd;
    logic                         hit_scan;
    logic                         emit;
    logic                         emit_found;
    logic [POS_BITS-1:0]          emit_addr;
    logic                         rearm;
    logic                         final_hit;
    logic [POS_BITS-1:0]          pos_inc;

    assign out_free = !out_valid_reg || out_chan.ready;
    assign q_ready  = (state_reg == ST_SCAN) && out_free;
    assign pop      = q_valid && q_ready;
    assign pos_inc  = pos_reg + POS_BITS'(1);

    assign out_chan.valid         = out_valid_reg;
    assign out_chan.found         = found_reg;
    assign out_chan.block_address = addr_reg;

    always_comb
    begin
        win_app                        = win_reg;
        zero_app                       = zero_reg;
        win_app[fill_reg[WIN_IDX_BITS-1:0]]  = q_item.data_byte;
        zero_app[fill_reg[WIN_IDX_BITS-1:0]] = q_item.zero;
        fill_app                       = fill_reg + FILL_BITS'(1);
        full_app                       = (fill_app == FILL_BITS'(WIN_DEPTH));
    end

    assign js = judge(win_app, zero_app[0], 1'b1, run_reg, skip_reg, pos_reg,
                      req_reg, aggr_reg);
    assign jd = judge(win_reg, zero_reg[0], 1'b0, run_reg, skip_reg, pos_reg,
                      req_reg, aggr_reg);
    assign hit_scan  = full_app && js.hit;
    assign final_hit = run_complete(jd.run, req_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SCAN:
            begin
                if (pop && !done_reg && !hit_scan && q_item.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_free && (jd.hit || fill_reg == FILL_BITS'(1)))
                begin
                    state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_SCAN;
            end
        endcase
    end

    always_comb
    begin
        win_next       = win_reg;
        zero_next      = zero_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        run_next       = run_reg;
        skip_next      = skip_reg;
        done_next      = done_reg;
        req_next       = req_reg;
        start_next     = start_reg;
        aggr_next      = aggr_reg;
        emit           = 1'b0;
        emit_found     = 1'b0;
        emit_addr      = '0;
        rearm          = 1'b0;

        case (state_reg)
            ST_SCAN:
            begin
                if (pop)
                begin
                    if (!done_reg)
                    begin
                        win_next  = win_app;
                        zero_next = zero_app;
                        fill_next = fill_app;
                        if (full_app)
                        begin
                            run_next  = js.run;
                            skip_next = js.skip;
                            if (js.shift)
                            begin
                                win_next  = win_app >> 8;
                                zero_next = zero_app >> 1;
                                fill_next = fill_app - FILL_BITS'(1);
                                pos_next  = pos_inc;
                            end
                        end
                        if (hit_scan)
                        begin
                            emit       = 1'b1;
                            emit_found = 1'b1;
                            emit_addr  = js.addr;
                            done_next  = 1'b1;
                        end
                    end
                    if (q_item.last && (done_reg || hit_scan))
                    begin
                        rearm = 1'b1;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    if (jd.hit)
                    begin
                        emit       = 1'b1;
                        emit_found = 1'b1;
                        emit_addr  = jd.addr;
                        rearm      = 1'b1;
                    end
                    else
                    begin
                        run_next  = jd.run;
                        skip_next = jd.skip;
                        win_next  = win_reg >> 8;
                        zero_next = zero_reg >> 1;
                        fill_next = fill_reg - FILL_BITS'(1);
                        pos_next  = pos_inc;
                        if (fill_reg == FILL_BITS'(1))
                        begin
                            emit       = 1'b1;
                            emit_found = final_hit;
                            emit_addr  = final_hit
                                         ? pos_inc - POS_BITS'(run_need(req_reg)) : '0;
                            rearm      = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                rearm = 1'b1;
            end
        endcase

        if (rearm)
        begin
            fill_next = '0;
            pos_next  = POS_BITS'(start_reg);
            run_next  = '0;
            skip_next = '0;
            done_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_REQUEST_SIZE:
                begin
                    req_next = cfg_data[REQ_BITS-1:0];
                end
                CFG_START_OFFSET:
                begin
                    start_next = cfg_data;
                    if (fill_reg == '0 && !done_reg && run_reg == '0 && skip_reg == '0)
                    begin
                        pos_next = POS_BITS'(cfg_data);
                    end
                end
                CFG_AGGRESSIVE_MODE:
                begin
                    aggr_next = cfg_data[0];
                end
                default:
                begin
                    req_next = req_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        addr_next      = addr_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            found_next     = emit_found;
            addr_next      = ADDR_BITS'(emit_addr);
        end
        else if (out_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg   <= win_next;
        zero_reg  <= zero_next;
        found_reg <= found_next;
        addr_reg  <= addr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SCAN;
            fill_reg      <= '0;
            pos_reg       <= '0;
            run_reg       <= '0;
            skip_reg      <= '0;
            done_reg      <= 1'b0;
            req_reg       <= REQ_BITS'(1);
            start_reg     <= '0;
            aggr_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            run_reg       <= run_next;
            skip_reg      <= skip_next;
            done_reg      <= done_next;
            req_reg       <= req_next;
            start_reg     <= start_next;
            aggr_reg      <= aggr_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hdl/free_space_run_finder_unit.sv
`timescale 1ns / 1ps
// Free space run finder.
// in_chan carries image bytes in ascending position order with an end-of-image
// mark on the last byte; out_chan carries one result per image: found and the
// header address (zero when nothing was found). Both use valid/ready; a
// transfer happens when both are high.
// Configuration (request size, start offset, aggressive mode) goes through the
// cfg_we/cfg_index/cfg_data write port; the user must write it only while the
// block is idle, as the block itself does not enforce this.
// Throughput: one byte per cycle while the output register can move and the
// window is not draining an image end. A four-entry queue sits after the input
// and takes up to four bytes while a result waits in the output register.
// A byte is judged at the edge that pops the byte seven positions later, once
// that later byte has passed through the queue; a find is in the output register
// from that same edge. On the last byte the window of up to seven bytes still
// pending drains one byte per cycle while the output register can move, until
// the result is emitted; the next image's bytes wait in the queue meanwhile.
// Reset empties the queue, clears the output, and loads request size 1,
// start offset 0 and aggressive mode off.
// When out_chan.ready is low with a result held, the scan halts, and the
// queue fills and drops in_chan.ready.

module free_space_run_finder_unit
    import fsrf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    fsrf_in_if.sink                   in_chan,
    fsrf_out_if.source                out_chan
);

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    fsrf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_chan (in_chan),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_ready (q_ready)
    );

    fsrf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_ready   (q_ready),
        .out_chan  (out_chan)
    );

endmodule

FILE: test/free_space_run_finder_unit_tb.sv
`timescale 1ns / 1ps

module free_space_run_finder_unit_tb;
    import fsrf_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 32;
    localparam int RANDOM_BYTES = 600;
    localparam int CALM_BYTES   = 480;
    localparam int LONG_HOLD    = 300;

    typedef enum logic [1:0] {
        FILL_ZERO,
        FILL_ONES,
        FILL_SPARSE,
        FILL_NOISE
    } fill_t;

    typedef struct packed {
        logic        set_cfg;
        logic [14:0] req;
        logic [23:0] start;
        logic        aggr;
        int          len;
        fill_t       fill;
        int          tag_at;
        logic [15:0] tag_size;
        logic        tag_good;
        int          pause_at;
        logic        known;
        logic        found;
        logic [23:0] addr;
    } image_plan_t;

    typedef struct packed {
        logic        found;
        logic [23:0] addr;
    } scan_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    fsrf_in_if  in_chan ();
    fsrf_out_if out_chan ();

    free_space_run_finder_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_chan   (in_chan),
        .out_chan  (out_chan)
    );

    // scan state mirror
    logic [7:0]           win_bytes [0:WIN_DEPTH-1];
    int unsigned          win_fill;
    logic [POS_BITS-1:0]  scan_pos;
    logic [RUN_BITS-1:0]  run_len;
    logic [SKIP_BITS-1:0] skip_left;
    logic                 scan_over;
    logic [REQ_BITS-1:0]  req_size;
    logic [23:0]          start_off;
    logic                 aggr_on;

    scan_result_t results_due [$];
    scan_result_t typed_result;
    logic         typed_pending;

    int error_count;
    int long_hold;
    int src_idle_pct;
    int sink_idle_pct;
    bit calm;

    image_plan_t directed_plans [0:15] = '{
        '{1'b0, 15'd1,      24'h000000, 1'b0, 9,     FILL_ZERO,  -1, 16'h0000, 1'b0, -1,
          1'b1, 1'b1, 24'h000000},
        '{1'b1, 15'd1,      24'h000000, 1'b0, 8,     FILL_ZERO,  -1, 16'h0000, 1'b0, -1,
          1'b1, 1'b0, 24'h000000},
        '{1'b1, 15'd0,      24'h000000, 1'b0, 40,    FILL_ZERO,  -1, 16'h0000, 1'b0, -1,
          1'b1, 1'b0, 24'h000000},
        '{1'b1, 15'h7FFF,   24'h000000, 1'b1, 40,    FILL_ONES,  -1, 16'h0000, 1'b0, -1,
          1'b1, 1'b0, 24'h000000},
        '{1'b1, 15'h7FF8,   24'h000000, 1'b0, 40,    FILL_ZERO,  -1, 16'h0000, 1'b0, -1,
          1'b1, 1'b0, 24'h000000},
        '{1'b1, 15'd8,      24'h007FF8, 1'b0, 30,    FILL_ZERO,  -1, 16'h0000, 1'b0, -1,
          1'b1, 1'b1, 24'h008000},
        '{1'b1, 15'd1,      24'hFFFFF7, 1'b0, 12,    FILL_ZERO,  -1, 16'h0000, 1'b0, -1,
          1'b1, 1'b1, 24'hFFFFF7},
        '{1'b1, 15'd1,      24'hFFFFFF, 1'b0, 12,    FILL_ZERO,  -1, 16'h0000, 1'b0, -1,
          1'b1, 1'b1, 24'h000000},
        '{1'b1, 15'd1,      24'h000000, 1'b1, 30,    FILL_ONES,  0,  16'h0004, 1'b1, -1,
          1'b1, 1'b1, 24'h00000D},
        '{1'b1, 15'd1,      24'h000000, 1'b0, 30,    FILL_ZERO,  0,  16'h0004, 1'b0, -1,
          1'b0, 1'b0, 24'h000000},
        '{1'b1, 15'd2,      24'h000040, 1'b0, 20,    FILL_ZERO,  13, 16'h0000, 1'b1, -1,
          1'b0, 1'b0, 24'h000000},
        '{1'b1, 15'd2,      24'h000040, 1'b0, 20,    FILL_ZERO,  12, 16'h0001, 1'b1, -1,
          1'b0, 1'b0, 24'h000000},
        '{1'b1, 15'd1,      24'h000000, 1'b1, 30,    FILL_ONES,  0,  16'hFFFF, 1'b1, -1,
          1'b1, 1'b0, 24'h000000},
        '{1'b1, 15'd1,      24'h000000, 1'b0, 20,    FILL_ONES,  -1, 16'h0000, 1'b0, -1,
          1'b1, 1'b0, 24'h000000},
        '{1'b1, 15'd1,      24'h000100, 1'b0, 40,    FILL_ZERO,  -1, 16'h0000, 1'b0, -1,
          1'b1, 1'b1, 24'h000100},
        '{1'b1, 15'd3,      24'h07FFF0, 1'b1, 48,    FILL_NOISE, -1, 16'h0000, 1'b0, -1,
          1'b0, 1'b0, 24'h000000}
    };

    function automatic void flag_error(input string what);
        error_count++;
        if (error_count <= 10)
        begin
            $display("%s", what);
        end
    endfunction

    function automatic void rearm_scan();
        for (int k = 0; k < WIN_DEPTH; k++)
        begin
            win_bytes[k] = '0;
        end
        win_fill  = 0;
        scan_pos  = start_off;
        run_len   = '0;
        skip_left = '0;
        scan_over = 1'b0;
    endfunction

    function automatic logic run_met();
        return (req_size != '0) && (req_size <= MAX_REQUEST)
               && (run_len == {1'b0, req_size} + 16'(HEADER_BYTES));
    endfunction

    function automatic logic [POS_BITS-1:0] header_pos();
        return scan_pos - POS_BITS'({1'b0, req_size} + 16'(HEADER_BYTES));
    endfunction

    function automatic logic judge_front(input int unsigned avail,
                                         output logic [POS_BITS-1:0] addr);
        logic [15:0] sz;
        logic [15:0] inv;
        addr = '0;
        if (skip_left != '0)
        begin
            skip_left = skip_left - SKIP_BITS'(1);
        end
        else if (run_met())
        begin
            addr = header_pos();
            return 1'b1;
        end
        else
        begin
            if (scan_pos[BANK_BITS-1:0] == '0)
            begin
                run_len = '0;
            end
            sz  = {win_bytes[5], win_bytes[4]};
            inv = ~{win_bytes[7], win_bytes[6]};
            if (avail >= WIN_DEPTH && win_bytes[0] == TAG_S && win_bytes[1] == TAG_T
                && win_bytes[2] == TAG_A && win_bytes[3] == TAG_R)
            begin
                if (sz != inv)
                begin
                    run_len = (run_len == RUN_MAX) ? run_len : run_len + RUN_BITS'(1);
                end
                else
                begin
                    skip_left = {1'b0, sz} + SKIP_BITS'(HEADER_BYTES);
                    run_len   = '0;
                end
            end
            else if (win_bytes[0] == 8'h00 || aggr_on)
            begin
                run_len = (run_len == RUN_MAX) ? run_len : run_len + RUN_BITS'(1);
            end
            else
            begin
                run_len = '0;
            end
        end
        for (int k = 0; k < WIN_DEPTH - 1; k++)
        begin
            win_bytes[k] = win_bytes[k + 1];
        end
        win_bytes[WIN_DEPTH - 1] = '0;
        if (win_fill > 0)
        begin
            win_fill--;
        end
        scan_pos = scan_pos + POS_BITS'(1);
        return 1'b0;
    endfunction

    function automatic void take_byte(input logic [7:0] data, input logic last);
        logic [POS_BITS-1:0] addr;
        logic                hit;
        scan_result_t        res;
        hit  = 1'b0;
        addr = '0;
        if (!scan_over)
        begin
            if (win_fill < WIN_DEPTH)
            begin
                win_bytes[win_fill] = data;
                win_fill++;
            end
            if (win_fill == WIN_DEPTH)
            begin
                hit = judge_front(WIN_DEPTH, addr);
            end
            if (!hit && last)
            begin
                while (!hit && win_fill > 0)
                begin
                    hit = judge_front(win_fill, addr);
                end
                if (!hit && run_met())
                begin
                    addr = header_pos();
                    hit  = 1'b1;
                end
            end
            if (hit || last)
            begin
                res.found = hit;
                res.addr  = hit ? addr : '0;
                if (typed_pending)
                begin
                    res           = typed_result;
                    typed_pending = 1'b0;
                end
                results_due.insert(results_due.size(), res);
                scan_over = 1'b1;
            end
        end
        if (last)
        begin
            rearm_scan();
        end
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            CFG_REQUEST_SIZE:
            begin
                req_size = value[REQ_BITS-1:0];
            end
            CFG_START_OFFSET:
            begin
                start_off = value[23:0];
                if (win_fill == 0 && !scan_over && run_len == '0 && skip_left == '0)
                begin
                    scan_pos = value[23:0];
                end
            end
            CFG_AGGRESSIVE_MODE:
            begin
                aggr_on = value[0];
            end
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_random_reg(input logic [CFG_INDEX_BITS-1:0] idx);
        logic [CFG_DATA_BITS-1:0] value;
        int                       pick;
        pick = $urandom_range(0, 9);
        case (idx)
            CFG_REQUEST_SIZE:
            begin
                if (pick < 8)
                    value = 24'($urandom_range(1, 24));
                else if (pick == 8)
                    value = 24'($urandom_range(0, 1) ? 0 : $urandom_range(32761, 32767));
                else
                    value = 24'($urandom_range(1, 32760));
            end
            CFG_START_OFFSET:
            begin
                if (pick < 4)
                    value = 24'($urandom_range(0, 255));
                else if (pick < 7)
                    value = 24'($urandom_range(0, 511) * 32768 - $urandom_range(0, 20));
                else if (pick < 9)
                    value = 24'($urandom);
                else
                    value = 24'hFFFFFF - 24'($urandom_range(0, 20));
            end
            default:
            begin
                value = 24'($urandom_range(0, 1));
            end
        endcase
        write_reg(idx, value);
    endtask

    task automatic settle();
        while (results_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_item(input logic [7:0] data, input logic last);
        if (!calm && $urandom_range(0, 99) < src_idle_pct)
        begin
            in_chan.valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_chan.valid        = 1'b1;
        in_chan.data_byte    = data;
        in_chan.end_of_image = last;
        @(posedge clk);
        while (!in_chan.ready)
        begin
            @(posedge clk);
        end
        take_byte(data, last);
        @(negedge clk);
        in_chan.valid = 1'b0;
    endtask

    task automatic send_image(input image_plan_t plan);
        logic [7:0]  image [$];
        logic [7:0]  tag_bytes [0:7];
        logic [15:0] inv;
        if (plan.set_cfg)
        begin
            write_reg(CFG_REQUEST_SIZE, CFG_DATA_BITS'(plan.req));
            write_reg(CFG_START_OFFSET, plan.start);
            write_reg(CFG_AGGRESSIVE_MODE, CFG_DATA_BITS'(plan.aggr));
        end
        for (int i = 0; i < plan.len; i++)
        begin
            case (plan.fill)
                FILL_ZERO:   image.insert(image.size(), 8'h00);
                FILL_ONES:   image.insert(image.size(), 8'hFF);
                FILL_SPARSE: image.insert(image.size(), ($urandom_range(0, 15) == 0)
                                          ? 8'($urandom_range(1, 255)) : 8'h00);
                default:     image.insert(image.size(), 8'($urandom));
            endcase
        end
        inv          = ~plan.tag_size ^ (plan.tag_good ? 16'h0000 : 16'h0100);
        tag_bytes[0] = TAG_S;
        tag_bytes[1] = TAG_T;
        tag_bytes[2] = TAG_A;
        tag_bytes[3] = TAG_R;
        tag_bytes[4] = plan.tag_size[7:0];
        tag_bytes[5] = plan.tag_size[15:8];
        tag_bytes[6] = inv[7:0];
        tag_bytes[7] = inv[15:8];
        for (int k = 0; k < 8; k++)
        begin
            if (plan.tag_at >= 0 && plan.tag_at + k < plan.len)
            begin
                image[plan.tag_at + k] = tag_bytes[k];
            end
        end
        typed_pending      = plan.known;
        typed_result.found = plan.found;
        typed_result.addr  = plan.addr;
        for (int i = 0; i < plan.len; i++)
        begin
            if (i == plan.pause_at)
            begin
                settle();
                write_random_reg(CFG_INDEX_BITS'($urandom_range(0, 2)));
            end
            send_item(image[i], i == plan.len - 1);
        end
    endtask

    function automatic int pick_idle_pct();
        int pick;
        pick = $urandom_range(0, 2);
        return (pick == 0) ? 0 : (pick == 1) ? 5 : 25;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : result_sink
        int stall;
        stall          = 0;
        out_chan.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_hold > 0)
            begin
                out_chan.ready = 1'b0;
                long_hold--;
            end
            else if (stall > 0)
            begin
                out_chan.ready = 1'b0;
                stall--;
            end
            else if (!calm && $urandom_range(0, 99) < sink_idle_pct)
            begin
                out_chan.ready = 1'b0;
                stall          = $urandom_range(1, 11) - 1;
            end
            else
            begin
                out_chan.ready = 1'b1;
            end
        end
    end

    initial
    begin : result_check
        scan_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_chan.valid && out_chan.ready)
            begin
                if (results_due.size() == 0)
                begin
                    flag_error($sformatf("unexpected result: found=%0b addr=%06h",
                                         out_chan.found, out_chan.block_address));
                end
                else
                begin
                    want = results_due.pop_front();
                    if (out_chan.found !== want.found || out_chan.block_address !== want.addr)
                    begin
                        flag_error($sformatf(
                            {"result mismatch: expected found=%0b addr=%06h, ",
                             "got found=%0b addr=%06h"},
                            want.found, want.addr, out_chan.found, out_chan.block_address));
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        image_plan_t plan;
        int          random_bytes;
        int          pick;

        in_chan.valid        = 1'b0;
        in_chan.data_byte    = '0;
        in_chan.end_of_image = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        error_count          = 0;
        long_hold            = 0;
        src_idle_pct         = 0;
        sink_idle_pct        = 0;
        calm                 = 1'b0;
        typed_pending        = 1'b0;
        typed_result         = '0;
        req_size             = 15'd1;
        start_off            = '0;
        aggr_on              = 1'b0;
        rearm_scan();

        wait (rst_n === 1'b1);
        @(negedge clk);

        for (int i = 0; i < 16; i++)
        begin
            src_idle_pct  = pick_idle_pct();
            sink_idle_pct = pick_idle_pct();
            settle();
            send_image(directed_plans[i]);
        end

        // hold the result side while short images pile up behind it
        settle();
        write_reg(CFG_REQUEST_SIZE, CFG_DATA_BITS'(1));
        write_reg(CFG_AGGRESSIVE_MODE, CFG_DATA_BITS'(0));
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        long_hold     = LONG_HOLD;
        plan          = '0;
        plan.tag_at   = -1;
        plan.pause_at = -1;
        plan.fill     = FILL_ZERO;
        for (int i = 0; i < 40; i++)
        begin
            plan.len = $urandom_range(1, 12);
            send_image(plan);
        end

        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            calm          = (random_bytes >= CALM_BYTES);
            src_idle_pct  = pick_idle_pct();
            sink_idle_pct = pick_idle_pct();
            settle();
            for (int r = 0; r < 3; r++)
            begin
                if ($urandom_range(0, 9) < 4)
                begin
                    write_random_reg(CFG_INDEX_BITS'(r));
                end
            end
            plan     = '0;
            plan.len = ($urandom_range(0, 4) == 0) ? $urandom_range(51, 120)
                                                   : $urandom_range(1, 50);
            pick      = $urandom_range(0, 9);
            plan.fill = (pick < 4) ? FILL_ZERO : (pick < 5) ? FILL_ONES
                        : (pick < 8) ? FILL_SPARSE : FILL_NOISE;
            plan.tag_at   = ($urandom_range(0, 9) < 4) ? $urandom_range(0, plan.len - 1) : -1;
            plan.tag_size = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 24));
            plan.tag_good = ($urandom_range(0, 9) < 7);
            plan.pause_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, plan.len - 1) : -1;
            send_image(plan);
            random_bytes += plan.len;
        end

        settle();
        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/fsrf_pkg.sv
hdl/fsrf_in_if.sv
hdl/fsrf_out_if.sv
hdl/fsrf_front.sv
hdl/fsrf_back.sv
hdl/free_space_run_finder_unit.sv
test/free_space_run_finder_unit_tb.sv
